/* src/ppmis_pkg.sv */
// shared types, constants and saturation helper for the ppm interface-state pipeline
// used by ppmis_face and ppm_interface_states_top; depends on nothing else
`default_nettype none

package ppmis_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TIME_STEP       = 3'd0,
        REG_ADIABATIC_INDEX = 3'd1,
        REG_PRESSURE_FLOOR  = 3'd2,
        REG_DENSITY_FLOOR   = 3'd3,
        REG_GRAVITY_ACCEL   = 3'd4,
        REG_GRAVITY_ENABLE  = 3'd5,
        REG_SWEEP_DIRECTION = 3'd6
    } cfg_reg_e;

    localparam int IN_BYTES_W  = 384;
    localparam int OUT_BYTES_W = 256;
    localparam int KICK_W      = 46;

    // pipeline depths
    localparam int DIV1_STEPS = 48;
    localparam int SQRT_STEPS = 32;
    localparam int DIV2_STEPS = 31;
    localparam int FACE_LAT   = 5;
    localparam int PIPE_DEPTH = 3 + DIV1_STEPS + SQRT_STEPS + 1 + (DIV2_STEPS + 1) + 2 + FACE_LAT;

    // reciprocal of three for exact floor division of 32-bit values
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

    typedef struct packed {
        logic signed [31:0] p_left;
        logic signed [31:0] p_delta;
        logic signed [31:0] p_sixth;
        logic signed [31:0] u_left;
        logic signed [31:0] u_delta;
        logic signed [31:0] u_sixth;
        logic signed [31:0] r_left;
        logic signed [31:0] r_delta;
        logic signed [31:0] r_sixth;
    } coef_t;

    typedef struct packed {
        logic                      floor_en;
        logic [30:0]               floor_val;
        logic signed [KICK_W-1:0]  kick_left;
        logic signed [KICK_W-1:0]  kick_right;
    } face_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/ppmis_face.sv */
// five-stage face-state datapath for one quantity: left face of next cell, right face of this cell
// depends on ppmis_pkg (sat32, face_ctl_t)
`default_nettype none

module ppmis_face
    import ppmis_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [30:0]        cross_in,
    input  wire logic signed [31:0] comp,
    input  wire logic signed [31:0] a_in,
    input  wire logic signed [31:0] d_in,
    input  wire logic signed [31:0] s_in,
    input  wire face_ctl_t          ctl,
    output logic signed [31:0]      face_left,
    output logic signed [31:0]      face_right
);

    logic signed [63:0] fs_reg;
    logic signed [31:0] a1_reg, d1_reg;
    logic [30:0]        c1_reg;

    logic signed [31:0] tl_reg, tr_reg, a2_reg, d2_reg;
    logic [30:0]        c2_reg;

    logic signed [63:0] ctl_reg, ctr_reg;
    logic signed [32:0] ad3_reg;
    logic signed [31:0] a3_reg;

    logic signed [31:0] l4_reg, r4_reg;
    logic signed [31:0] l5_reg, r5_reg;

    logic signed [63:0] fs_next;
    logic signed [31:0] fsq;
    logic signed [31:0] c_s;
    logic signed [31:0] lq, rq, l4_next, r4_next, lf, rf;
    logic signed [31:0] floor_s;

    // f * a6
    assign fs_next = comp * s_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            fs_reg <= fs_next;
            a1_reg <= a_in;
            d1_reg <= d_in;
            c1_reg <= cross_in;
        end
    end

    assign fsq = sat32(fs_reg >>> 16);

    always_ff @(posedge aclk) begin
        if (en) begin
            tl_reg <= sat32(64'(d1_reg) - 64'(fsq));
            tr_reg <= sat32(64'(d1_reg) + 64'(fsq));
            a2_reg <= a1_reg;
            d2_reg <= d1_reg;
            c2_reg <= c1_reg;
        end
    end

    assign c_s = $signed({1'b0, c2_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= c_s * tl_reg;
            ctr_reg <= c_s * tr_reg;
            ad3_reg <= 33'(a2_reg) + 33'(d2_reg);
            a3_reg  <= a2_reg;
        end
    end

    assign lq      = sat32(ctl_reg >>> 16);
    assign rq      = sat32(ctr_reg >>> 16);
    assign l4_next = sat32(64'(ad3_reg) - 64'(lq));
    assign r4_next = sat32(64'(a3_reg) + 64'(rq));

    always_ff @(posedge aclk) begin
        if (en) begin
            l4_reg <= l4_next;
            r4_reg <= r4_next;
        end
    end

    // floor then gravity kick
    assign floor_s = $signed({1'b0, ctl.floor_val});
    assign lf = (ctl.floor_en && (l4_reg < floor_s)) ? floor_s : l4_reg;
    assign rf = (ctl.floor_en && (r4_reg < floor_s)) ? floor_s : r4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            l5_reg <= sat32(64'(lf) + 64'(ctl.kick_left));
            r5_reg <= sat32(64'(rf) + 64'(ctl.kick_right));
        end
    end

    assign face_left  = l5_reg;
    assign face_right = r5_reg;

endmodule

`default_nettype wire

/* src/ppm_interface_states_top.sv */
// top level of the ppm characteristic interface-state pipeline
// depends on ppmis_pkg and ppmis_face
//
// usage
//   s_ channel: one cell per transfer (pressure, density, cell width, parabola
//   coefficients of pressure, velocity and density); m_ channel: one result
//   per cell (crossing factor, its complement, left face for the next cell
//   and right face of this cell)
//   cfg channel: register writes, always ready; the user must write only while
//   the block is idle, which the block does not enforce; unknown indexes are dropped
// throughput
//   one cell per cycle sustained while the output is not stalled; the pipeline
//   holds the bit-per-stage divisions (48 and 31 stages) and the
//   two-bit-per-stage square root (32 stages)
// reset
//   aresetn low clears all valid flags and loads register defaults; the
//   datapath registers carry no reset
// stall
//   the whole pipeline advances together; when m_tready is low the next
//   finished result goes into a skid register and the pipeline then holds,
//   so s_tready is a plain register output and nothing is lost or repeated
`default_nettype none

module ppm_interface_states_top
    import ppmis_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // pressure, density, cell_width, p_left, p_delta, p_sixth,
    // u_left, u_delta, u_sixth, r_left, r_delta, r_sixth, zero pad
    input  wire logic [IN_BYTES_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // crossing_factor, crossing_complement, p_face_next_left, u_face_next_left,
    // r_face_next_left, p_face_right, u_face_right, r_face_right, zero pad
    output logic [OUT_BYTES_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data
);

    // ---------------- configuration registers ----------------
    logic [30:0]        time_step_reg;
    logic [30:0]        adiabatic_index_reg;
    logic [30:0]        pressure_floor_reg;
    logic [30:0]        density_floor_reg;
    logic signed [31:0] gravity_accel_reg;
    logic               gravity_enable_reg;
    logic               sweep_direction_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg       <= '0;
            adiabatic_index_reg <= 31'd109227;
            pressure_floor_reg  <= 31'd1;
            density_floor_reg   <= 31'd1;
            gravity_accel_reg   <= '0;
            gravity_enable_reg  <= 1'b0;
            sweep_direction_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_e'(cfg_index))
                REG_TIME_STEP:       time_step_reg       <= cfg_data[30:0];
                REG_ADIABATIC_INDEX: adiabatic_index_reg <= cfg_data[30:0];
                REG_PRESSURE_FLOOR:  pressure_floor_reg  <= cfg_data[30:0];
                REG_DENSITY_FLOOR:   density_floor_reg   <= cfg_data[30:0];
                REG_GRAVITY_ACCEL:   gravity_accel_reg   <= cfg_data;
                REG_GRAVITY_ENABLE:  gravity_enable_reg  <= cfg_data[0];
                REG_SWEEP_DIRECTION: sweep_direction_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // half-step gravity kick, derived from static configuration
    logic signed [63:0]       kick_prod_reg;
    logic signed [KICK_W-1:0] kick_left_reg, kick_right_reg;
    logic signed [63:0]       kick_shift;

    assign kick_shift = kick_prod_reg >>> 17;

    always_ff @(posedge aclk) begin
        kick_prod_reg  <= $signed({1'b0, time_step_reg}) * gravity_accel_reg;
        kick_left_reg  <= (!sweep_direction_reg) ? kick_shift[KICK_W-1:0] : '0;
        kick_right_reg <= (sweep_direction_reg && gravity_enable_reg)
                          ? kick_shift[KICK_W-1:0] : '0;
    end

    // ---------------- flow control ----------------
    logic                    pipe_en;
    logic [PIPE_DEPTH-1:0]   vld_reg, vld_next;
    logic                    out_valid_reg, skid_valid_reg;
    logic [OUT_BYTES_W-1:0]  out_reg, skid_reg;
    logic [OUT_BYTES_W-1:0]  last_data;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 0: input capture ----------------
    logic [30:0] p0_reg, rho0_reg, dx0_reg;
    coef_t       coef0_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p0_reg    <= s_tdata[30:0];
            rho0_reg  <= s_tdata[61:31];
            dx0_reg   <= s_tdata[92:62];
            coef0_reg <= '{p_left:  s_tdata[124:93],  p_delta: s_tdata[156:125],
                           p_sixth: s_tdata[188:157], u_left:  s_tdata[220:189],
                           u_delta: s_tdata[252:221], u_sixth: s_tdata[284:253],
                           r_left:  s_tdata[316:285], r_delta: s_tdata[348:317],
                           r_sixth: s_tdata[380:349]};
        end
    end

    // ---------------- stage 1: gamma * p ----------------
    logic [61:0] prod1_reg;
    logic [30:0] rho1_reg, dx1_reg;
    coef_t       coef1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod1_reg <= adiabatic_index_reg * p0_reg;
            rho1_reg  <= rho0_reg;
            dx1_reg   <= dx0_reg;
            coef1_reg <= coef0_reg;
        end
    end

    // ---------------- c2 = gamma*p / rho, one quotient bit per stage ----------------
    typedef struct packed {
        logic        ovf;
        logic [30:0] rem;
        logic [47:0] nq;
        logic [30:0] rho;
        logic [30:0] dx;
        coef_t       coef;
    } div1_t;

    div1_t d1_reg [0:DIV1_STEPS];

    // setup: quotient of 2^48 or more saturates the sound speed (zero density too)
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d1_reg[0].ovf  <= ({17'b0, prod1_reg[61:48]} >= rho1_reg);
            d1_reg[0].rem  <= {17'b0, prod1_reg[61:48]};
            d1_reg[0].nq   <= prod1_reg[47:0];
            d1_reg[0].rho  <= rho1_reg;
            d1_reg[0].dx   <= dx1_reg;
            d1_reg[0].coef <= coef1_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV1_STEPS; k++) begin : g_div1
            div1_t       st_next;
            logic [31:0] sh;
            always_comb begin
                st_next = d1_reg[k];
                sh      = {d1_reg[k].rem, d1_reg[k].nq[47]};
                if (sh >= {1'b0, d1_reg[k].rho}) begin
                    st_next.rem = 31'(sh - {1'b0, d1_reg[k].rho});
                    st_next.nq  = {d1_reg[k].nq[46:0], 1'b1};
                end else begin
                    st_next.rem = sh[30:0];
                    st_next.nq  = {d1_reg[k].nq[46:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    d1_reg[k+1] <= st_next;
                end
            end
        end
    endgenerate

    // ---------------- sound speed = sqrt(c2 << 16), two radicand bits per stage ----------------
    typedef struct packed {
        logic        sat;
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] x;
        logic [30:0] dx;
        coef_t       coef;
    } sq_t;

    sq_t sq_reg [0:SQRT_STEPS-1];
    sq_t sq_src [0:SQRT_STEPS-1];

    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            sq_t         st_next;
            logic [35:0] t, trial;
            if (k == 0) begin : g_first
                always_comb begin
                    sq_src[k].sat  = d1_reg[DIV1_STEPS].ovf;
                    sq_src[k].rem  = '0;
                    sq_src[k].root = '0;
                    sq_src[k].x    = {d1_reg[DIV1_STEPS].nq, 16'b0};
                    sq_src[k].dx   = d1_reg[DIV1_STEPS].dx;
                    sq_src[k].coef = d1_reg[DIV1_STEPS].coef;
                end
            end else begin : g_next
                assign sq_src[k] = sq_reg[k-1];
            end
            always_comb begin
                st_next = sq_src[k];
                t       = {sq_src[k].rem, sq_src[k].x[63:62]};
                trial   = {2'b0, sq_src[k].root, 2'b01};
                st_next.x = {sq_src[k].x[61:0], 2'b00};
                if (t >= trial) begin
                    st_next.rem  = 34'(t - trial);
                    st_next.root = {sq_src[k].root[30:0], 1'b1};
                end else begin
                    st_next.rem  = t[33:0];
                    st_next.root = {sq_src[k].root[30:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    sq_reg[k] <= st_next;
                end
            end
        end
    endgenerate

    // ---------------- c * dt ----------------
    logic [31:0] snd;
    logic [62:0] prod2_reg;
    logic [30:0] dx2_reg;
    coef_t       coef2_reg;

    assign snd = sq_reg[SQRT_STEPS-1].sat ? 32'hFFFFFFFF : sq_reg[SQRT_STEPS-1].root;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod2_reg <= snd * time_step_reg;
            dx2_reg   <= sq_reg[SQRT_STEPS-1].dx;
            coef2_reg <= sq_reg[SQRT_STEPS-1].coef;
        end
    end

    // ---------------- crossing factor = c*dt / (2 dx), one bit per stage ----------------
    typedef struct packed {
        logic        ovf;
        logic [31:0] rem;
        logic [30:0] nq;
        logic [31:0] dv;
        coef_t       coef;
    } div2_t;

    div2_t d2_reg [0:DIV2_STEPS];

    // setup: zero width or a quotient of 2^31 or more saturates
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d2_reg[0].ovf  <= (prod2_reg[62:31] >= {dx2_reg, 1'b0});
            d2_reg[0].rem  <= prod2_reg[62:31];
            d2_reg[0].nq   <= prod2_reg[30:0];
            d2_reg[0].dv   <= {dx2_reg, 1'b0};
            d2_reg[0].coef <= coef2_reg;
        end
    end

    generate
        for (k = 0; k < DIV2_STEPS; k++) begin : g_div2
            div2_t       st_next;
            logic [32:0] sh;
            always_comb begin
                st_next = d2_reg[k];
                sh      = {d2_reg[k].rem, d2_reg[k].nq[30]};
                if (sh >= {1'b0, d2_reg[k].dv}) begin
                    st_next.rem = 32'(sh - {1'b0, d2_reg[k].dv});
                    st_next.nq  = {d2_reg[k].nq[29:0], 1'b1};
                end else begin
                    st_next.rem = sh[31:0];
                    st_next.nq  = {d2_reg[k].nq[29:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    d2_reg[k+1] <= st_next;
                end
            end
        end
    endgenerate

    // ---------------- complement: 1 - floor(4C/3) = 1 - C - floor(C/3) ----------------
    logic [30:0] cross_c;
    logic [30:0] cross_c_reg;
    logic [62:0] third_prod_reg;
    coef_t       coef_c_reg;

    assign cross_c = d2_reg[DIV2_STEPS].ovf ? 31'h7FFFFFFF : d2_reg[DIV2_STEPS].nq;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cross_c_reg    <= cross_c;
            third_prod_reg <= cross_c * RECIP3;
            coef_c_reg     <= d2_reg[DIV2_STEPS].coef;
        end
    end

    logic signed [63:0] comp_wide;
    logic [30:0]        cross_f_reg;
    logic signed [31:0] comp_f_reg;
    coef_t              coef_f_reg;

    assign comp_wide = 64'sd65536 - $signed({33'b0, cross_c_reg})
                       - $signed({34'b0, third_prod_reg[62:33]});

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cross_f_reg <= cross_c_reg;
            comp_f_reg  <= sat32(comp_wide);
            coef_f_reg  <= coef_c_reg;
        end
    end

    // ---------------- face states ----------------
    face_ctl_t          ctl_p, ctl_u, ctl_r;
    logic signed [31:0] p_fl, p_fr, u_fl, u_fr, r_fl, r_fr;

    assign ctl_p = '{floor_en: 1'b1, floor_val: pressure_floor_reg,
                     kick_left: '0, kick_right: '0};
    assign ctl_u = '{floor_en: 1'b0, floor_val: '0,
                     kick_left: kick_left_reg, kick_right: kick_right_reg};
    assign ctl_r = '{floor_en: 1'b1, floor_val: density_floor_reg,
                     kick_left: '0, kick_right: '0};

    ppmis_face u_face_p (
        .aclk(aclk), .en(pipe_en), .cross_in(cross_f_reg), .comp(comp_f_reg),
        .a_in(coef_f_reg.p_left), .d_in(coef_f_reg.p_delta), .s_in(coef_f_reg.p_sixth),
        .ctl(ctl_p), .face_left(p_fl), .face_right(p_fr)
    );

    ppmis_face u_face_u (
        .aclk(aclk), .en(pipe_en), .cross_in(cross_f_reg), .comp(comp_f_reg),
        .a_in(coef_f_reg.u_left), .d_in(coef_f_reg.u_delta), .s_in(coef_f_reg.u_sixth),
        .ctl(ctl_u), .face_left(u_fl), .face_right(u_fr)
    );

    ppmis_face u_face_r (
        .aclk(aclk), .en(pipe_en), .cross_in(cross_f_reg), .comp(comp_f_reg),
        .a_in(coef_f_reg.r_left), .d_in(coef_f_reg.r_delta), .s_in(coef_f_reg.r_sixth),
        .ctl(ctl_r), .face_left(r_fl), .face_right(r_fr)
    );

    // crossing factor and complement travel alongside the face stages
    logic [30:0]        cross_dl_reg [0:FACE_LAT-1];
    logic signed [31:0] comp_dl_reg  [0:FACE_LAT-1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cross_dl_reg[0] <= cross_f_reg;
            comp_dl_reg[0]  <= comp_f_reg;
            for (int i = 1; i < FACE_LAT; i++) begin
                cross_dl_reg[i] <= cross_dl_reg[i-1];
                comp_dl_reg[i]  <= comp_dl_reg[i-1];
            end
        end
    end

    assign last_data = {5'b0, r_fr[30:0], u_fr, p_fr[30:0], r_fl[30:0], u_fl, p_fl[30:0],
                        comp_dl_reg[FACE_LAT-1], cross_dl_reg[FACE_LAT-1]};

    // ---------------- output register with skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[PIPE_DEPTH-1];
            end
        end else if (pipe_en && vld_reg[PIPE_DEPTH-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : last_data;
        end else if (pipe_en && vld_reg[PIPE_DEPTH-1]) begin
            skid_reg <= last_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without a stalled output");

    a_stall_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && pipe_en && vld_reg[PIPE_DEPTH-1]) |=> skid_valid_reg)
        else $error("finished result dropped during output stall");

    a_frozen_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pipe_en && !s_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while held");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for ppm_interface_states_top: streams cells through the
// pipeline and compares every result with a bit-exact predictor held here
// depends on ppmis_pkg and the rtl of the block, nothing else
`timescale 1ns / 1ps

module tb_top;
    import ppmis_pkg::*;

    localparam int  CLK_HALF   = 5;
    localparam int  LIMIT      = 400000;
    localparam int  DRAIN      = 140;
    localparam int  HOLD_LEN   = 400;
    localparam logic [2:0] REG_UNUSED = 3'd7;   // index past the register list

    // one cell as it travels on s_tdata
    typedef struct packed {
        logic [30:0]       pressure;
        logic [30:0]       density;
        logic [30:0]       cell_width;
        logic [8:0][31:0]  coef;   // p_left .. r_sixth
    } cell_t;

    typedef logic [7:0][31:0] faces_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_BYTES_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [2:0]             cfg_index;
    logic [31:0]            cfg_data;

    // shadow copy of the registers
    logic [30:0]        dt_q, gamma_q, pfloor_q, rfloor_q;
    logic signed [31:0] grav_q;
    logic               grav_en_q, dir_q;

    faces_t      expected_faces[$];
    int          fail_count;
    int          cells_sent;
    int          faces_seen;
    int          src_idle_pct;
    int          sink_stall_pct;
    logic        sink_hold;
    int unsigned cycles;

    // result field layout, lowest bit first
    int    field_off[8]   = '{0, 31, 63, 94, 126, 157, 188, 220};
    int    field_w[8]     = '{31, 32, 31, 32, 31, 31, 32, 31};
    string field_name[8]  = '{"crossing_factor", "crossing_complement", "p_face_next_left",
                              "u_face_next_left", "r_face_next_left", "p_face_right",
                              "u_face_right", "r_face_right"};

    ppm_interface_states_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),   // pressure, density, cell_width, nine coefficients, pad
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // crossing factor, complement, six faces, pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // q16.16 product, floor rounding, saturated
    function automatic longint qmul(input longint a, input longint b);
        longint prod;
        prod = a * b;
        return clamp_s32(prod >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint left_face_val(input longint c, input longint f,
                                             input longint a, input longint d, input longint s);
        longint t;
        t = clamp_s32(d - qmul(f, s));
        return clamp_s32(a + d - qmul(c, t));
    endfunction

    function automatic longint right_face_val(input longint c, input longint f,
                                              input longint a, input longint d, input longint s);
        longint t;
        t = clamp_s32(d + qmul(f, s));
        return clamp_s32(a + qmul(c, t));
    endfunction

    function automatic longint apply_floor(input longint v, input logic [30:0] fl);
        return (v < longint'(fl)) ? longint'(fl) : v;
    endfunction

    function automatic faces_t predict_faces(input cell_t c);
        longint unsigned c2, snd, crossing;
        longint cf, comp, kick, pl, ul, rl, pr, ur, rr;
        longint v[9];
        faces_t r;
        for (int k = 0; k < 9; k++) v[k] = longint'($signed(c.coef[k]));
        if (c.density == 0) begin
            snd = 64'hFFFF_FFFF;   // zero density: sound speed pinned at its top
        end else begin
            c2 = (longint'(gamma_q) * longint'(c.pressure)) / longint'(c.density);
            if (c2 >= (64'd1 << 48)) snd = 64'hFFFF_FFFF;
            else begin
                snd = int_sqrt(c2 << 16);
                if (snd > 64'hFFFF_FFFF) snd = 64'hFFFF_FFFF;
            end
        end
        if (c.cell_width == 0) crossing = 64'h7FFF_FFFF;
        else begin
            crossing = (snd * longint'(dt_q)) / (2 * longint'(c.cell_width));
            if (crossing > 64'h7FFF_FFFF) crossing = 64'h7FFF_FFFF;
        end
        cf   = longint'(crossing);
        comp = clamp_s32(65536 - longint'((4 * crossing) / 3));
        kick = (longint'(dt_q) * longint'(grav_q)) >>> 17;
        pl = apply_floor(left_face_val(cf, comp, v[0], v[1], v[2]), pfloor_q);
        ul = left_face_val(cf, comp, v[3], v[4], v[5]);
        rl = apply_floor(left_face_val(cf, comp, v[6], v[7], v[8]), rfloor_q);
        pr = apply_floor(right_face_val(cf, comp, v[0], v[1], v[2]), pfloor_q);
        ur = right_face_val(cf, comp, v[3], v[4], v[5]);
        rr = apply_floor(right_face_val(cf, comp, v[6], v[7], v[8]), rfloor_q);
        // half-step gravity lands on one face only
        if (dir_q == 1'b0) ul = clamp_s32(ul + kick);
        else if (grav_en_q) ur = clamp_s32(ur + kick);
        r[0] = crossing[31:0];
        r[1] = comp[31:0];
        r[2] = pl[31:0];
        r[3] = ul[31:0];
        r[4] = rl[31:0];
        r[5] = pr[31:0];
        r[6] = ur[31:0];
        r[7] = rr[31:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // results sampled at the falling edge; the transfer completes at the next rising edge
    always @(negedge aclk) begin
        faces_t want;
        logic [31:0] got, mask;
        if (aresetn && m_tvalid && m_tready) begin
            faces_seen++;
            if (expected_faces.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_faces.pop_front();
                for (int k = 0; k < 8; k++) begin
                    mask = (field_w[k] == 32) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
                    got  = m_tdata[field_off[k] +: 32] & mask;
                    if (got !== (want[k] & mask))
                        report_mismatch(field_name[k], got, want[k] & mask);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off while sink_hold is set
    always @(posedge aclk) begin
        if (sink_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic logic [IN_BYTES_W-1:0] pack_cell(input cell_t c);
        logic [IN_BYTES_W-1:0] d;
        d = '0;
        d[30:0]  = c.pressure;
        d[61:31] = c.density;
        d[92:62] = c.cell_width;
        for (int k = 0; k < 9; k++) d[93 + 32*k +: 32] = c.coef[k];
        return d;
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_cell(input cell_t c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cell(c);
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        expected_faces.push_back(predict_faces(c));
        cells_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_faces.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // drops cfg_valid after the write and waits before returning, so that back-to-back writes never drive twice at once
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TIME_STEP:       dt_q      = val[30:0];
            REG_ADIABATIC_INDEX: gamma_q   = val[30:0];
            REG_PRESSURE_FLOOR:  pfloor_q  = val[30:0];
            REG_DENSITY_FLOOR:   rfloor_q  = val[30:0];
            REG_GRAVITY_ACCEL:   grav_q    = val;
            REG_GRAVITY_ENABLE:  grav_en_q = val[0];
            REG_SWEEP_DIRECTION: dir_q     = val[0];
            default: ;   // dropped by the block too
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [31:0] dt, input logic [31:0] gam,
                             input logic [31:0] pfl, input logic [31:0] rfl,
                             input logic [31:0] g, input logic [31:0] en,
                             input logic [31:0] dir);
        wait_idle();
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_ADIABATIC_INDEX, gam);
        write_reg(REG_PRESSURE_FLOOR, pfl);
        write_reg(REG_DENSITY_FLOOR, rfl);
        write_reg(REG_GRAVITY_ACCEL, g);
        write_reg(REG_GRAVITY_ENABLE, en);
        write_reg(REG_SWEEP_DIRECTION, dir);
    endtask

    // mostly plausible gas states, some raw noise over the full field width
    function automatic cell_t random_cell();
        cell_t c;
        int mode;
        mode = $urandom_range(9);
        if (mode < 3) begin
            c.pressure   = 31'($urandom());
            c.density    = 31'($urandom());
            c.cell_width = 31'($urandom());
            for (int k = 0; k < 9; k++) c.coef[k] = $urandom();
        end else begin
            c.pressure   = 31'($urandom_range(32'h0040_0000, 32'h0000_1000));
            c.density    = 31'($urandom_range(32'h0040_0000, 32'h0000_1000));
            c.cell_width = 31'($urandom_range(32'h0004_0000, 32'h0000_4000));
            for (int k = 0; k < 9; k++)
                c.coef[k] = $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
        end
        return c;
    endfunction

    function automatic cell_t make_cell(input logic [30:0] p, input logic [30:0] rho,
                                        input logic [30:0] dx, input logic [31:0] coef);
        cell_t c;
        c.pressure   = p;
        c.density    = rho;
        c.cell_width = dx;
        for (int k = 0; k < 9; k++) c.coef[k] = (k % 2) ? ~coef : coef;
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // moderate step, gravity on left face
        write_all(32'h0000_0400, 32'h0001_AAAB, 32'h0000_0010, 32'h0000_0010,
                  32'hFFF6_0000, 32'h0, 32'h0);
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h0001_0000));
        send_cell(make_cell(31'h0, 31'h0001_0000, 31'h0001_0000, 32'h0));            // no pressure
        send_cell(make_cell(31'h7FFF_FFFF, 31'h0001_0000, 31'h0001_0000, 32'h7FFF_FFFF));
        send_cell(make_cell(31'h0001_0000, 31'h0, 31'h0001_0000, 32'h8000_0000));     // zero density
        send_cell(make_cell(31'h0001_0000, 31'h7FFF_FFFF, 31'h0001_0000, 32'hFFFF_FFFF));
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0, 32'h0000_1234));     // zero width
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h7FFF_FFFF, 32'h8000_0001));
        send_cell(make_cell(31'h7FFF_FFFF, 31'h1, 31'h1, 32'h7FFF_FFFF));             // huge sound speed
        send_cell(make_cell(31'h7FFF_FFFF, 31'h0, 31'h0, 32'h8000_0000));
        // extremes of the registers, gravity on the right face
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h1);
        send_cell(make_cell(31'h7FFF_FFFF, 31'h1, 31'h1, 32'h7FFF_FFFF));
        send_cell(make_cell(31'h0000_0100, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000));
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'hFFFF_0000));
        wait_idle();
        write_reg(REG_GRAVITY_ACCEL, 32'h8000_0000);
        send_cell(make_cell(31'h0001_0000, 31'h0002_0000, 31'h0000_8000, 32'h8000_0000));
        // right direction but gravity off: no kick anywhere
        wait_idle();
        write_reg(REG_GRAVITY_ENABLE, 32'h0);
        send_cell(make_cell(31'h0001_0000, 31'h0002_0000, 31'h0000_8000, 32'h0001_0000));
        // floors at their top, index past the list is dropped
        wait_idle();
        write_reg(REG_PRESSURE_FLOOR, 32'h7FFF_FFFF);
        write_reg(REG_DENSITY_FLOOR, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h0000_0000);
        write_reg(REG_TIME_STEP, 32'h0);
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h7FFF_FFFF));
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h8000_0000));
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int n);
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        for (int i = 0; i < n; i++) send_cell(random_cell());
    endtask

    task automatic test_random();
        write_all(32'h0000_0800, 32'h0001_AAAB, 32'h1, 32'h1, 32'h0002_0000, 32'h0, 32'h0);
        test_random_phase(0, 0, 110);
        write_all($urandom(), $urandom(), $urandom_range(32'h100), $urandom_range(32'h100),
                  $urandom(), 32'h1, 32'h1);
        test_random_phase(77, 0, 110);
        write_all(32'h0000_2000, 32'h0001_6666, 32'h0000_4000, 32'h0000_4000,
                  32'hFFFE_0000, 32'h1, 32'h0);
        test_random_phase(0, 77, 110);
        write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
        test_random_phase(15, 15, 110);
    endtask

    // receiver holds off long enough for the pipeline to fill and stop s_tready
    task automatic test_backpressure();
        write_all(32'h0000_1000, 32'h0001_AAAB, 32'h1, 32'h1, 32'h0001_0000, 32'h1, 32'h1);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_LEN) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 200; i++) send_cell(random_cell());
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TIME_STEP;
        cfg_data       = '0;
        sink_hold      = 1'b0;
        cycles         = 0;
        fail_count     = 0;
        cells_sent     = 0;
        faces_seen     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // register defaults after reset
        dt_q      = '0;
        gamma_q   = 31'd109227;
        pfloor_q  = 31'd1;
        rfloor_q  = 31'd1;
        grav_q    = '0;
        grav_en_q = 1'b0;
        dir_q     = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults first, before any write
        send_cell(make_cell(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h0001_0000));
        test_directed();
        test_random();
        test_backpressure();

        wait_idle();
        repeat (DRAIN) @(posedge aclk);
        $display("%0d cells sent, %0d results checked, over reset, extreme and random",
                 cells_sent, faces_seen);
        $display("register settings with idle, stall and hold-off phases");
        if (fail_count == 0 && expected_faces.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
